/* hdl/ttf_pkg.sv */
package ttf_pkg;

  localparam int CoordW  = 32;
  localparam int DiffW   = CoordW + 1;
  localparam int ProdW   = 2 * DiffW;
  localparam int WideW   = ProdW + 2;
  localparam int CompW   = 16;
  localparam int ScaleW  = 30;
  localparam int LenW    = 7;
  localparam int InDataW  = 5 * CoordW;
  localparam int OutDataW = 9 * CompW;

  // Position of the highest set bit plus one; zero for a zero word.
  function automatic logic [LenW-1:0] bitlen_w(input logic [WideW-1:0] x);
    logic [LenW-1:0] n;
    n = '0;
    for (int i = 0; i < WideW; i++) begin
      if (x[i]) n = LenW'(i + 1);
    end
    return n;
  endfunction

  function automatic logic [WideW-1:0] mag_w(input logic signed [WideW-1:0] x);
    return x[WideW-1] ? WideW'(-x) : WideW'(x);
  endfunction

endpackage

/* hdl/triangle_tangent_frame.sv */
// Per-face tangent frame. Vertices arrive three to a face on the in_ item
// stream; the first two are held and the third launches the face. One
// result item per face leaves on out_: unit tangent, binormal and normal in
// signed Q1.15 (positive full scale saturates to 32767), and a degenerate flag
// in out_tuser that is set, with all nine components zero, when the UV
// determinant or any of the three vectors is zero. The third vertex occupies
// the block (for less time when the face turns out degenerate, for more while
// an earlier result still waits in the output register) and runs on one shared
// 33x33 multiplier (fourteen products for the determinant, tangent and
// binormal, six for the normal, three squares per vector), a 32-step square
// root per vector and a 16-step divider per component. in_tready stays low
// meanwhile. The result sits in an output register, so the first two vertices
// of the next face are taken while it waits.
module triangle_tangent_frame (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v
  input  logic [ttf_pkg::InDataW-1:0]   in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // tangent_x/y/z, binormal_x/y/z, normal_x/y/z
  output logic [ttf_pkg::OutDataW-1:0]  out_tdata,
  // degenerate
  output logic                          out_tuser
);
  import ttf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MAC, S_CHK, S_BITLEN, S_SCALE, S_SQ, S_SQRT, S_DIVLD, S_DIV,
    S_NEXT, S_DONE
  } state_t;

  state_t                      state_r;
  logic [1:0]                  face_slot_r;
  logic [CoordW-1:0]           hpos_r [6];
  logic [CoordW-1:0]           htex_r [4];
  logic signed [DiffW-1:0]     e1_r [3];
  logic signed [DiffW-1:0]     e2_r [3];
  logic signed [DiffW-1:0]     du1_r, dv1_r, du2_r, dv2_r;
  // 0: determinant, 1..3: tangent (later normal), 4..6: binormal
  logic signed [WideW-1:0]     wreg_r [7];
  logic [4:0]                  cnt_r;
  logic [1:0]                  comp_r;
  logic [1:0]                  pass_r;
  logic                        det_neg_r;
  logic                        degen_r;
  logic signed [ProdW-1:0]     prod_r;
  logic signed [WideW-1:0]     acc_r;
  logic [LenW-1:0]             lmax_r;
  logic [ScaleW-1:0]           c_r [3];
  logic [63:0]                 sx_r, sr_r;
  logic [32:0]                 rem_r;
  logic [15:0]                 quot_r;
  logic [45:0]                 num_r;
  logic signed [CompW-1:0]     res_r [9];
  logic                        out_valid_r;
  logic [OutDataW-1:0]         out_data_r;
  logic                        out_user_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  logic [CoordW-1:0] in_f [5];
  always_comb begin
    for (int i = 0; i < 5; i++) in_f[i] = in_tdata[i*CoordW +: CoordW];
  end

  function automatic logic signed [DiffW-1:0] dif(input logic [CoordW-1:0] a,
                                                  input logic [CoordW-1:0] b);
    return $signed({a[CoordW-1], a}) - $signed({b[CoordW-1], b});
  endfunction

  // Shared multiplier operand select.
  logic [2:0]              pair;
  logic                    half;
  logic signed [DiffW-1:0] mul_a, mul_b;
  logic signed [ProdW-1:0] mul_p;
  logic [2:0]              last_pair;

  assign pair      = cnt_r[4:2];
  assign half      = cnt_r[1];
  assign last_pair = (pass_r == 2'd2) ? 3'd2 : 3'd6;

  function automatic logic signed [DiffW-1:0] ext16(input logic signed [CompW-1:0] x);
    return DiffW'(x);
  endfunction

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_SQ) begin
      case (cnt_r[1:0])
        2'd0: mul_a = $signed({3'b000, c_r[0]});
        2'd1: mul_a = $signed({3'b000, c_r[1]});
        2'd2: mul_a = $signed({3'b000, c_r[2]});
        default: mul_a = '0;
      endcase
      mul_b = mul_a;
    end else if (pass_r == 2'd2) begin
      // normal = tangent x binormal
      case (pair)
        3'd0: begin
          mul_a = half ? ext16(res_r[2]) : ext16(res_r[1]);
          mul_b = half ? ext16(res_r[4]) : ext16(res_r[5]);
        end
        3'd1: begin
          mul_a = half ? ext16(res_r[0]) : ext16(res_r[2]);
          mul_b = half ? ext16(res_r[5]) : ext16(res_r[3]);
        end
        default: begin
          mul_a = half ? ext16(res_r[1]) : ext16(res_r[0]);
          mul_b = half ? ext16(res_r[3]) : ext16(res_r[4]);
        end
      endcase
    end else begin
      case (pair)
        3'd0: begin mul_a = half ? du2_r : du1_r; mul_b = half ? dv1_r : dv2_r; end
        3'd1: begin mul_a = half ? dv1_r : dv2_r; mul_b = half ? e2_r[0] : e1_r[0]; end
        3'd2: begin mul_a = half ? dv1_r : dv2_r; mul_b = half ? e2_r[1] : e1_r[1]; end
        3'd3: begin mul_a = half ? dv1_r : dv2_r; mul_b = half ? e2_r[2] : e1_r[2]; end
        3'd4: begin mul_a = half ? du2_r : du1_r; mul_b = half ? e1_r[0] : e2_r[0]; end
        3'd5: begin mul_a = half ? du2_r : du1_r; mul_b = half ? e1_r[1] : e2_r[1]; end
        3'd6: begin mul_a = half ? du2_r : du1_r; mul_b = half ? e1_r[2] : e2_r[2]; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  assign mul_p = mul_a * mul_b;

  logic [2:0] mac_tgt;
  assign mac_tgt = (pass_r == 2'd2) ? pair + 3'd1 : pair;

  // Normalization unit: one component read per cycle.
  logic [2:0]              base;
  logic [1:0]              ci;
  logic [2:0]              widx;
  logic signed [WideW-1:0] w_sel;
  logic [WideW-1:0]        w_mag;
  logic [LenW-1:0]         w_len, lmax_nxt;
  logic [WideW-1:0]        w_scaled;
  logic                    flip;

  assign base  = (pass_r == 2'd1) ? 3'd4 : 3'd1;
  assign ci    = (state_r == S_DIVLD || state_r == S_DIV) ? comp_r : cnt_r[1:0];
  assign widx  = base + {1'b0, ci};
  assign w_sel = wreg_r[widx];
  assign w_mag = mag_w(w_sel);
  assign w_len = bitlen_w(w_mag);
  assign lmax_nxt = (w_len > lmax_r) ? w_len : lmax_r;
  assign flip  = (pass_r == 2'd2) ? 1'b0 : det_neg_r;
  assign w_scaled = (lmax_r > LenW'(ScaleW)) ? (w_mag >> (lmax_r - LenW'(ScaleW)))
                                             : (w_mag << (LenW'(ScaleW) - lmax_r));

  // Square root step.
  logic [63:0] sq_bit, sq_t, sx_nxt, sr_nxt;
  assign sq_bit = 64'd1 << (6'd62 - {cnt_r, 1'b0});
  assign sq_t   = sr_r + sq_bit;
  always_comb begin
    if (sx_r >= sq_t) begin
      sx_nxt = sx_r - sq_t;
      sr_nxt = (sr_r >> 1) + sq_bit;
    end else begin
      sx_nxt = sx_r;
      sr_nxt = sr_r >> 1;
    end
  end

  // Divider step.
  logic [31:0] len;
  logic [45:0] num_ld;
  logic [32:0] rem_sh, rem_nxt;
  logic [15:0] quot_nxt;
  logic [16:0] q_sat;
  logic signed [CompW-1:0] q_out;
  logic        q_neg;
  logic [3:0]  res_idx;

  assign len    = sr_r[31:0];
  assign num_ld = {1'b0, c_r[comp_r], 15'd0} + {15'd0, len[31:1]};
  assign rem_sh = {rem_r[31:0], num_r[~cnt_r[3:0]]};
  always_comb begin
    if (rem_sh >= {1'b0, len}) begin
      rem_nxt  = rem_sh - {1'b0, len};
      quot_nxt = {quot_r[14:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      quot_nxt = {quot_r[14:0], 1'b0};
    end
    q_sat = (quot_nxt > 16'd32768) ? 17'd32768 : {1'b0, quot_nxt};
    q_neg = w_sel[WideW-1] ^ flip;
    if (q_neg)
      q_out = CompW'(-$signed(q_sat));
    else
      q_out = (q_sat > 17'd32767) ? 16'sd32767 : $signed(q_sat[15:0]);
  end

  always_comb begin
    case (pass_r)
      2'd0:    res_idx = {2'b00, comp_r};
      2'd1:    res_idx = 4'd3 + {2'b00, comp_r};
      default: res_idx = 4'd6 + {2'b00, comp_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      face_slot_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop the taken result; a reload in S_DONE takes over instead.
      if (out_valid_r && out_tready && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (face_slot_r == 2'd0) begin
              for (int i = 0; i < 3; i++) hpos_r[i] <= in_f[i];
              htex_r[0] <= in_f[3];
              htex_r[1] <= in_f[4];
              face_slot_r <= 2'd1;
            end else if (face_slot_r == 2'd1) begin
              for (int i = 0; i < 3; i++) hpos_r[3+i] <= in_f[i];
              htex_r[2] <= in_f[3];
              htex_r[3] <= in_f[4];
              face_slot_r <= 2'd2;
            end else begin
              for (int i = 0; i < 3; i++) begin
                e1_r[i] <= dif(hpos_r[3+i], hpos_r[i]);
                e2_r[i] <= dif(in_f[i], hpos_r[i]);
              end
              du1_r <= dif(htex_r[2], htex_r[0]);
              dv1_r <= dif(htex_r[3], htex_r[1]);
              du2_r <= dif(in_f[3], htex_r[0]);
              dv2_r <= dif(in_f[4], htex_r[1]);
              face_slot_r <= 2'd0;
              degen_r <= 1'b0;
              pass_r  <= 2'd0;
              cnt_r   <= '0;
              state_r <= S_MAC;
            end
          end
        end
        S_MAC: begin
          case (cnt_r[1:0])
            2'd0, 2'd2: prod_r <= mul_p;
            2'd1:       acc_r  <= WideW'(prod_r);
            default:    wreg_r[mac_tgt] <= acc_r - WideW'(prod_r);
          endcase
          if (cnt_r[1:0] == 2'd3 && pair == last_pair) begin
            state_r <= S_CHK;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_CHK: begin
          cnt_r  <= '0;
          lmax_r <= '0;
          if (pass_r == 2'd0 && wreg_r[0] == '0) begin
            degen_r <= 1'b1;
            state_r <= S_DONE;
          end else begin
            if (pass_r == 2'd0) det_neg_r <= wreg_r[0][WideW-1];
            state_r <= S_BITLEN;
          end
        end
        S_BITLEN: begin
          lmax_r <= lmax_nxt;
          if (cnt_r == 5'd2) begin
            cnt_r <= '0;
            if (lmax_nxt == '0) begin
              degen_r <= 1'b1;
              state_r <= S_DONE;
            end else begin
              state_r <= S_SCALE;
            end
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_SCALE: begin
          c_r[ci] <= w_scaled[ScaleW-1:0];
          if (cnt_r == 5'd2) begin
            cnt_r   <= '0;
            acc_r   <= '0;
            state_r <= S_SQ;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_SQ: begin
          if (cnt_r != 5'd3) prod_r <= mul_p;
          if (cnt_r != 5'd0) acc_r <= acc_r + WideW'(prod_r);
          if (cnt_r == 5'd3) begin
            sx_r    <= acc_r[63:0] + prod_r[63:0];
            sr_r    <= '0;
            cnt_r   <= '0;
            state_r <= S_SQRT;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_SQRT: begin
          sx_r  <= sx_nxt;
          sr_r  <= sr_nxt;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            comp_r  <= '0;
            state_r <= S_DIVLD;
          end
        end
        S_DIVLD: begin
          if (len == '0) begin
            degen_r <= 1'b1;
            state_r <= S_DONE;
          end else begin
            num_r   <= num_ld;
            rem_r   <= {3'b000, num_ld[45:16]};
            quot_r  <= '0;
            cnt_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r  <= rem_nxt;
          quot_r <= quot_nxt;
          cnt_r  <= cnt_r + 5'd1;
          if (cnt_r == 5'd15) begin
            res_r[res_idx] <= q_out;
            if (comp_r == 2'd2) begin
              state_r <= S_NEXT;
            end else begin
              comp_r  <= comp_r + 2'd1;
              state_r <= S_DIVLD;
            end
          end
        end
        S_NEXT: begin
          cnt_r  <= '0;
          lmax_r <= '0;
          if (pass_r == 2'd0) begin
            pass_r  <= 2'd1;
            state_r <= S_BITLEN;
          end else if (pass_r == 2'd1) begin
            pass_r  <= 2'd2;
            state_r <= S_MAC;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // Hold the result until the output register is free.
          if (!out_valid_r || out_tready) begin
            for (int i = 0; i < 9; i++)
              out_data_r[i*CompW +: CompW] <= degen_r ? '0 : res_r[i];
            out_user_r  <= degen_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/ttf_checker.sv */
module ttf_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [ttf_pkg::OutDataW-1:0]  out_tdata,
  input logic                          out_tuser
);
  import ttf_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("degenerate result carries nonzero vectors");

  a_frame_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata != '0)
    else $error("valid frame is all zero");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready after reset");

endmodule

bind triangle_tangent_frame ttf_checker u_ttf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* sim/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttf_pkg::*;

  localparam int        CYCLE_LIMIT = 600000;
  localparam int        RANDOM_ITEMS = 400;
  localparam int        SETTLE_CYCLES = 400;
  localparam int        HOLD_CYCLES = 3000;
  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] CMAX = 32'h7fff_ffff;
  localparam logic [31:0] CMIN = 32'h8000_0000;

  typedef logic signed [71:0] wide_t;

  // One tangent frame as it leaves the block.
  typedef struct packed {
    logic [OutDataW-1:0] comps;
    logic                degen;
  } frame_t;

  // One row of the directed stimulus.
  typedef struct {
    logic [InDataW-1:0] vtx;
    bit                 typed;
    frame_t             frame;
  } row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tuser;

  triangle_tangent_frame dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Mirror of the face assembly state.
  int                 face_slot;
  logic [InDataW-1:0] held_vtx [2];

  frame_t frames_due [$];
  int     error_count;
  int     frames_seen;
  bit     burst_mode;

  initial begin
    forever #1 clk = ~clk;
  end

  // Abort a hung run.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch on frame %0d: %s got %h want %h", frames_seen, what, got, want);
    error_count++;
  endtask

  function automatic logic [InDataW-1:0] vtx(input logic [31:0] x, input logic [31:0] y,
                                             input logic [31:0] z, input logic [31:0] u,
                                             input logic [31:0] v);
    return {v, u, z, y, x};
  endfunction

  function automatic frame_t frame_of(input logic [15:0] tx, input logic [15:0] ty,
                                      input logic [15:0] tz, input logic [15:0] bx,
                                      input logic [15:0] by, input logic [15:0] bz,
                                      input logic [15:0] nx, input logic [15:0] ny,
                                      input logic [15:0] nz, input logic dg);
    frame_t f;
    f.comps = {nz, ny, nx, bz, by, bx, tz, ty, tx};
    f.degen = dg;
    return f;
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Scale to 30 significant bits, take the integer length, round each
  // component to Q1.15. Returns 0 for a zero vector or zero length.
  function automatic bit unit_vec(input wide_t v [3], input bit flip,
                                  output logic signed [15:0] o [3]);
    logic [71:0] m [3];
    logic [63:0] c [3];
    logic [63:0] sum, len, q;
    int          top, bl;
    top = 0;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      o[i] = '0;
      m[i] = v[i] < 0 ? -v[i] : v[i];
      bl = 0;
      for (int k = 0; k < 72; k++) if (m[i][k]) bl = k + 1;
      if (bl > top) top = bl;
    end
    if (top == 0) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      c[i] = top > 30 ? 64'(m[i] >> (top - 30)) : 64'(m[i] << (30 - top));
      sum += c[i] * c[i];
    end
    len = floor_sqrt(sum);
    if (len == 0) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      q = (c[i] * 64'd32768 + len / 2) / len;
      if (q > 32768) q = 32768;
      if ((v[i] < 0) != flip) o[i] = 16'(-q);
      else o[i] = q > 32767 ? 16'sd32767 : 16'(q);
    end
    return 1'b1;
  endfunction

  // Take one accepted vertex; return 1 with the frame when it closes a face.
  function automatic bit predict_frame(input logic [InDataW-1:0] d, output frame_t f);
    wide_t p [3][3];
    wide_t t [3][2];
    wide_t e1 [3], e2 [3], tv [3], bv [3], nv [3], tw [3], bw [3];
    wide_t du1, dv1, du2, dv2, det;
    logic signed [15:0] tan [3], bin [3], nrm [3];
    bit ok;
    f = '0;
    if (face_slot < 2) begin
      held_vtx[face_slot] = d;
      face_slot++;
      return 1'b0;
    end
    face_slot = 0;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++)
        p[k][i] = $signed(k < 2 ? held_vtx[k][32*i +: 32] : d[32*i +: 32]);
      for (int i = 0; i < 2; i++)
        t[k][i] = $signed(k < 2 ? held_vtx[k][96 + 32*i +: 32] : d[96 + 32*i +: 32]);
    end
    for (int i = 0; i < 3; i++) begin
      e1[i] = p[1][i] - p[0][i];
      e2[i] = p[2][i] - p[0][i];
    end
    du1 = t[1][0] - t[0][0];
    dv1 = t[1][1] - t[0][1];
    du2 = t[2][0] - t[0][0];
    dv2 = t[2][1] - t[0][1];
    det = du1 * dv2 - du2 * dv1;
    ok = det != 0;
    if (ok) begin
      for (int i = 0; i < 3; i++) begin
        tv[i] = dv2 * e1[i] - dv1 * e2[i];
        bv[i] = du1 * e2[i] - du2 * e1[i];
      end
      ok = unit_vec(tv, det < 0, tan);
      if (ok) ok = unit_vec(bv, det < 0, bin);
    end
    if (ok) begin
      for (int i = 0; i < 3; i++) begin
        tw[i] = tan[i];
        bw[i] = bin[i];
      end
      nv[0] = tw[1] * bw[2] - tw[2] * bw[1];
      nv[1] = tw[2] * bw[0] - tw[0] * bw[2];
      nv[2] = tw[0] * bw[1] - tw[1] * bw[0];
      ok = unit_vec(nv, 1'b0, nrm);
    end
    if (ok)
      f = frame_of(tan[0], tan[1], tan[2], bin[0], bin[1], bin[2],
                   nrm[0], nrm[1], nrm[2], 1'b0);
    else
      f = frame_of('0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1);
    return 1'b1;
  endfunction

  function automatic int idle_draw();
    return burst_mode ? 0 : $urandom_range(0, 14);
  endfunction

  // Offer one vertex after a random gap and hold it until taken; keep valid
  // high across back-to-back items.
  task automatic send_vertex(input logic [InDataW-1:0] d, input bit typed, input frame_t tf);
    int     gap;
    frame_t f;
    gap = idle_draw();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    if (predict_frame(d, f)) frames_due.push_back(typed ? tf : f);
  endtask

  task automatic drain();
    while (frames_due.size() != 0) @(posedge clk);
  endtask

  // Random coordinate: mostly full range, sometimes small values near zero.
  function automatic logic [31:0] coord(input bit narrow);
    return narrow ? 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000 : $urandom;
  endfunction

  // Result side: random ready gaps, one long hold-off, check every frame.
  initial begin
    int     gap;
    frame_t want;
    string  names [9];
    names = '{"tangent_x", "tangent_y", "tangent_z", "binormal_x", "binormal_y",
              "binormal_z", "normal_x", "normal_y", "normal_z"};
    @(posedge rst_n);
    forever begin
      gap = (frames_seen == 20) ? HOLD_CYCLES : idle_draw();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      if (frames_due.size() == 0) begin
        report("unexpected frame", out_tdata[31:0], 32'h0);
      end else begin
        want = frames_due.pop_front();
        for (int i = 0; i < 9; i++)
          if (out_tdata[16*i +: 16] !== want.comps[16*i +: 16])
            report(names[i], 32'(out_tdata[16*i +: 16]), 32'(want.comps[16*i +: 16]));
        if (out_tuser !== want.degen) report("degenerate", 32'(out_tuser), 32'(want.degen));
      end
      frames_seen++;
    end
  end

  // Mode flips between random idling and runs with none.
  initial begin
    forever begin
      repeat ($urandom_range(50, 400)) @(posedge clk);
      burst_mode = ~burst_mode;
    end
  end

  // Stimulus and end of run.
  initial begin
    row_t          rows [$];
    row_t          r;
    frame_t        none;
    logic [31:0]   nx [3][5];
    int            mode, sent;
    none = '0;
    error_count = 0;
    frames_seen = 0;
    face_slot = 0;
    burst_mode = 1'b0;

    // Unit face: tangent along x, binormal along y, normal along z.
    rows.push_back('{vtx(0, 0, 0, 0, 0), 0, none});
    rows.push_back('{vtx(ONE, 0, 0, ONE, 0), 0, none});
    rows.push_back('{vtx(0, ONE, 0, 0, ONE), 1,
                     frame_of(16'sd32767, 0, 0, 0, 16'sd32767, 0, 0, 0, 16'sd32767, 0)});
    // Mirrored u: negative determinant flips tangent and binormal signs.
    rows.push_back('{vtx(0, 0, 0, 0, 0), 0, none});
    rows.push_back('{vtx(ONE, 0, 0, -ONE, 0), 0, none});
    rows.push_back('{vtx(0, ONE, 0, 0, ONE), 1,
                     frame_of(16'h8000, 0, 0, 0, 16'sd32767, 0, 0, 0, 16'h8000, 0)});
    // All zero: determinant zero.
    rows.push_back('{vtx(0, 0, 0, 0, 0), 0, none});
    rows.push_back('{vtx(0, 0, 0, 0, 0), 0, none});
    rows.push_back('{vtx(0, 0, 0, 0, 0), 1, frame_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 1)});
    // Coincident positions with a good UV map: zero tangent.
    rows.push_back('{vtx(5, 5, 5, 0, 0), 0, none});
    rows.push_back('{vtx(5, 5, 5, ONE, 0), 0, none});
    rows.push_back('{vtx(5, 5, 5, 0, ONE), 1, frame_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 1)});
    // Extremes of every field.
    rows.push_back('{vtx(CMIN, CMIN, CMIN, CMIN, CMIN), 0, none});
    rows.push_back('{vtx(CMAX, CMAX, CMAX, CMAX, CMIN), 0, none});
    rows.push_back('{vtx(CMIN, CMAX, 0, CMIN, CMAX), 0, none});
    rows.push_back('{vtx(CMAX, CMIN, CMAX, CMAX, CMAX), 0, none});
    rows.push_back('{vtx(CMIN, CMAX, CMIN, CMIN, CMIN), 0, none});
    rows.push_back('{vtx('1, '1, '1, CMAX, CMIN), 0, none});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_vertex(rows[i].vtx, rows[i].typed, rows[i].frame);
    // Sender pause: let every frame out before the random faces.
    in_tvalid <= 1'b0;
    drain();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 19);
      for (int k = 0; k < 3; k++)
        for (int i = 0; i < 5; i++) nx[k][i] = coord(mode >= 8 && mode < 16);
      if (mode == 16) begin
        // Shared UV on every vertex: zero determinant.
        for (int k = 1; k < 3; k++) begin
          nx[k][3] = nx[0][3];
          nx[k][4] = nx[0][4];
        end
      end else if (mode == 17) begin
        // Parallel UV deltas where the 32-bit sum does not wrap: zero determinant with distinct texcoords.
        nx[2][3] = nx[1][3] + (nx[1][3] - nx[0][3]);
        nx[2][4] = nx[1][4] + (nx[1][4] - nx[0][4]);
      end else if (mode == 18) begin
        // One shared position: zero edges.
        for (int k = 1; k < 3; k++)
          for (int i = 0; i < 3; i++) nx[k][i] = nx[0][i];
      end
      for (int k = 0; k < 3; k++)
        send_vertex(vtx(nx[k][0], nx[k][1], nx[k][2], nx[k][3], nx[k][4]), 0, none);
      sent += 3;
      if (sent >= RANDOM_ITEMS / 2 && sent < RANDOM_ITEMS / 2 + 3) begin
        in_tvalid <= 1'b0;
        drain();
      end
    end
    in_tvalid <= 1'b0;

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
